// ===== sv/ffpa_pkg.sv =====
package ffpa_pkg;

    localparam int POOL_BYTES   = 4096;
    localparam int HEADER_BYTES = 16;
    localparam int MAX_BLOCKS   = 256;

    localparam int OFF_W  = 12;
    localparam int SIZE_W = 13;
    localparam int SLOT_W = $clog2(MAX_BLOCKS);
    localparam int LINK_W = SLOT_W + 1;
    localparam int CNT_W  = SLOT_W + 1;

    localparam logic [LINK_W-1:0] NO_SLOT = LINK_W'(MAX_BLOCKS);

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_FIT    = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    // One block list entry.
    typedef struct packed {
        logic [SIZE_W-1:0] start;
        logic [SIZE_W-1:0] size;
        logic              used;
        logic [LINK_W-1:0] next;
        logic [LINK_W-1:0] prev;
    } seg_t;

endpackage

// ===== sv/ffpa_if.sv =====
interface ffpa_in_if;
    import ffpa_pkg::*;
    logic              valid;
    logic              ready;
    logic              action;
    logic [OFF_W-1:0]  req_size;
    logic [OFF_W-1:0]  address;
    modport source (output valid, action, req_size, address, input ready);
    modport sink (input valid, action, req_size, address, output ready);
endinterface

interface ffpa_out_if;
    import ffpa_pkg::*;
    logic              valid;
    logic              ready;
    logic [1:0]        status;
    logic [OFF_W-1:0]  block_offset;
    modport source (output valid, status, block_offset, input ready);
    modport sink (input valid, status, block_offset, output ready);
endinterface

// ===== sv/ffpa_seg_ram.sv =====
module ffpa_seg_ram
    import ffpa_pkg::*;
(
    input  logic              clk,
    input  logic              we,
    input  logic [SLOT_W-1:0] waddr,
    input  seg_t              wdata,
    input  logic [SLOT_W-1:0] raddr,
    output seg_t              rdata
);

    seg_t mem [MAX_BLOCKS];

    // Single write port, registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== sv/ffpa_spare_stack.sv =====
module ffpa_spare_stack
    import ffpa_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              pop,
    input  logic              push,
    input  logic [SLOT_W-1:0] push_slot,
    output logic              empty,
    output logic [SLOT_W-1:0] top_slot
);

    logic [SLOT_W-1:0] mem [MAX_BLOCKS];
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [SLOT_W-1:0] top_reg;

    // Entries written since reset, as flagged in wr_reg, hold pushed slots;
    // below the initial fill the reset content is MAX_BLOCKS-1-index.
    logic [MAX_BLOCKS-1:0] wr_reg;
    logic [SLOT_W-1:0]     rd_idx;

    assign empty = (count_reg == '0);
    assign count_next = push ? count_reg + CNT_W'(1) :
                        (pop && !empty) ? count_reg - CNT_W'(1) : count_reg;
    assign rd_idx = SLOT_W'(count_next - CNT_W'(1));

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[count_reg[SLOT_W-1:0]] <= push_slot;
        end
        top_reg <= mem[rd_idx];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= CNT_W'(MAX_BLOCKS - 1);
            wr_reg    <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_reg[count_reg[SLOT_W-1:0]] <= 1'b1;
            end
        end
    end

    logic [SLOT_W-1:0] top_idx_reg;
    logic              top_wr_reg;
    always_ff @(posedge clk)
    begin
        top_idx_reg <= rd_idx;
        top_wr_reg  <= wr_reg[rd_idx] || (push && rd_idx == count_reg[SLOT_W-1:0]);
    end

    // Reset content: slot MAX_BLOCKS-1 at the bottom, slot 1 on top.
    assign top_slot = top_wr_reg ? top_reg : SLOT_W'(MAX_BLOCKS - 1) - top_idx_reg;

endmodule

// ===== sv/first_fit_pool_allocator_top.sv =====
// A request walks the block list one entry per cycle, k entries with k up
// to MAX_BLOCKS, then splits or merges blocks before its result item is
// presented. One item at a time: no request is taken while one is in work
// or while its result waits to be taken.
// After reset a clearing pass writes all MAX_BLOCKS list entries; no item is
// accepted until it ends. Reset is asynchronous, active low.
module first_fit_pool_allocator_top
    import ffpa_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    ffpa_in_if.sink   in_ch,
    ffpa_out_if.source out_ch
);

    typedef enum logic [14:0] {
        S_CLEAR  = 15'b000000000000001,
        S_IDLE   = 15'b000000000000010,
        S_RD     = 15'b000000000000100,
        S_CHK    = 15'b000000000001000,
        S_POP    = 15'b000000000010000,
        S_WQ     = 15'b000000000100000,
        S_RDN    = 15'b000000001000000,
        S_WN     = 15'b000000010000000,
        S_FPRE   = 15'b000000100000000,
        S_FPCHK  = 15'b000001000000000,
        S_FNX    = 15'b000010000000000,
        S_FNCHK  = 15'b000100000000000,
        S_FNN    = 15'b001000000000000,
        S_FNNW   = 15'b010000000000000,
        S_DONE   = 15'b100000000000000
    } state_t;

    state_t state_reg, state_next;

    logic [SLOT_W-1:0] clr_reg;
    logic              act_reg;
    logic [OFF_W-1:0]  req_reg;
    logic [OFF_W-1:0]  addr_reg;
    logic [LINK_W-1:0] p_reg;
    logic [CNT_W-1:0]  steps_reg;
    seg_t              cur_reg;     // working copy of block p
    logic [SLOT_W-1:0] q_reg;
    logic [1:0]        st_reg;
    logic [OFF_W-1:0]  off_reg;
    logic              out_valid_reg;

    logic              we;
    logic [SLOT_W-1:0] waddr, raddr;
    seg_t              wdata, rdata;

    logic              sp_pop, sp_push, sp_empty;
    logic [SLOT_W-1:0] sp_push_slot, sp_top;

    ffpa_seg_ram u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    ffpa_spare_stack u_spare (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop       (sp_pop),
        .push      (sp_push),
        .push_slot (sp_push_slot),
        .empty     (sp_empty),
        .top_slot  (sp_top)
    );

    // Shared compare unit: fit check for allocate, match check for free.
    logic [SIZE_W-1:0] need;
    logic              hit;
    assign need = SIZE_W'(req_reg) + SIZE_W'(HEADER_BYTES);
    always_comb
    begin
        if (act_reg == ACT_ALLOC)
        begin
            hit = !rdata.used && (rdata.size >= need);
        end
        else
        begin
            hit = rdata.used &&
                  ((rdata.start + SIZE_W'(HEADER_BYTES)) == SIZE_W'(addr_reg));
        end
    end

    // Shared adder for merge: base size plus absorbed size plus a header.
    logic [SIZE_W-1:0] merged;
    assign merged = cur_reg.size + rdata.size + SIZE_W'(HEADER_BYTES);

    assign in_ch.ready         = (state_reg == S_IDLE) && !out_valid_reg;
    assign out_ch.valid        = out_valid_reg;
    assign out_ch.status       = st_reg;
    assign out_ch.block_offset = off_reg;

    // Working slot register of the free path.
    logic [SLOT_W-1:0] pre_reg;

    always_comb
    begin
        state_next   = state_reg;
        we           = 1'b0;
        waddr        = p_reg[SLOT_W-1:0];
        wdata        = cur_reg;
        raddr        = p_reg[SLOT_W-1:0];
        sp_pop       = 1'b0;
        sp_push      = 1'b0;
        sp_push_slot = p_reg[SLOT_W-1:0];
        unique case (state_reg)
            S_CLEAR:
            begin
                we           = 1'b1;
                waddr        = clr_reg;
                wdata.start  = '0;
                wdata.size   = (clr_reg == '0) ? SIZE_W'(POOL_BYTES - HEADER_BYTES) : '0;
                wdata.used   = 1'b0;
                wdata.next   = NO_SLOT;
                wdata.prev   = NO_SLOT;
                if (clr_reg == SLOT_W'(MAX_BLOCKS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_ch.valid && in_ch.ready)
                begin
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                state_next = S_CHK;
            end
            S_CHK:
            begin
                if (hit)
                begin
                    state_next = (act_reg == ACT_ALLOC) ? S_POP : S_FPRE;
                end
                else if (rdata.next == NO_SLOT ||
                         steps_reg == CNT_W'(MAX_BLOCKS - 1))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    raddr      = rdata.next[SLOT_W-1:0];
                    state_next = S_CHK;
                end
            end
            S_POP:
            begin
                // Pop a spare slot for the new tail block q; with none left, no fit.
                if (sp_empty)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    sp_pop     = 1'b1;
                    state_next = S_WQ;
                end
            end
            S_WQ:
            begin
                we          = 1'b1;
                waddr       = q_reg;
                wdata.start = cur_reg.start + cur_reg.size - SIZE_W'(req_reg);
                wdata.size  = SIZE_W'(req_reg);
                wdata.used  = 1'b1;
                wdata.prev  = p_reg;
                wdata.next  = cur_reg.next;
                state_next  = S_RDN;
            end
            S_RDN:
            begin
                // Shrink p and link it to q; fetch the old successor.
                we         = 1'b1;
                wdata.next = {1'b0, q_reg};
                wdata.size = cur_reg.size - need;
                raddr      = cur_reg.next[SLOT_W-1:0];
                state_next = (cur_reg.next == NO_SLOT) ? S_DONE : S_WN;
            end
            S_WN:
            begin
                we         = 1'b1;
                waddr      = cur_reg.next[SLOT_W-1:0];
                wdata      = rdata;
                wdata.prev = {1'b0, q_reg};
                state_next = S_DONE;
            end
            S_FPRE:
            begin
                raddr      = cur_reg.prev[SLOT_W-1:0];
                // With no predecessor, mark p free here.
                if (cur_reg.prev == NO_SLOT)
                begin
                    we         = 1'b1;
                    wdata.used = 1'b0;
                end
                state_next = (cur_reg.prev == NO_SLOT) ? S_FNX : S_FPCHK;
            end
            S_FPCHK:
            begin
                if (!rdata.used)
                begin
                    // Predecessor absorbs p.
                    we           = 1'b1;
                    waddr        = pre_reg;
                    wdata        = rdata;
                    wdata.next   = cur_reg.next;
                    wdata.size   = merged;
                    sp_push      = 1'b1;
                    sp_push_slot = p_reg[SLOT_W-1:0];
                end
                else
                begin
                    we         = 1'b1;
                    wdata.used = 1'b0;
                end
                state_next = S_FNX;
            end
            S_FNX:
            begin
                raddr      = cur_reg.next[SLOT_W-1:0];
                state_next = (cur_reg.next == NO_SLOT) ? S_FNNW : S_FNCHK;
            end
            S_FNCHK:
            begin
                we = 1'b1;
                if (!rdata.used)
                begin
                    wdata.next   = rdata.next;
                    wdata.size   = merged;
                    sp_push      = 1'b1;
                    sp_push_slot = cur_reg.next[SLOT_W-1:0];
                    raddr        = rdata.next[SLOT_W-1:0];
                    state_next   = (rdata.next == NO_SLOT) ? S_DONE : S_FNN;
                end
                else
                begin
                    // The successor stays; point it back at p, which may now be
                    // the predecessor that absorbed the freed block.
                    waddr      = cur_reg.next[SLOT_W-1:0];
                    wdata      = rdata;
                    wdata.prev = p_reg;
                    state_next = S_DONE;
                end
            end
            S_FNN:
            begin
                // Successor of the merged block points back at p.
                we         = 1'b1;
                waddr      = cur_reg.next[SLOT_W-1:0];
                wdata      = rdata;
                wdata.prev = p_reg;
                state_next = S_DONE;
            end
            S_FNNW:
            begin
                we         = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR)
            begin
                clr_reg <= clr_reg + SLOT_W'(1);
            end
            if (state_reg == S_DONE)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.valid && out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload and working registers.
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_ch.valid && in_ch.ready)
                begin
                    act_reg   <= in_ch.action;
                    req_reg   <= in_ch.req_size;
                    addr_reg  <= in_ch.address;
                    p_reg     <= '0;
                    steps_reg <= '0;
                    st_reg    <= ST_OK;
                    off_reg   <= '0;
                end
            end
            S_CHK:
            begin
                cur_reg <= rdata;
                if (hit)
                begin
                    pre_reg <= rdata.prev[SLOT_W-1:0];
                end
                else if (rdata.next == NO_SLOT ||
                         steps_reg == CNT_W'(MAX_BLOCKS - 1))
                begin
                    st_reg <= (act_reg == ACT_ALLOC) ? ST_NO_FIT : ST_NOT_FOUND;
                end
                else
                begin
                    p_reg     <= rdata.next;
                    steps_reg <= steps_reg + CNT_W'(1);
                end
            end
            S_POP:
            begin
                if (sp_empty)
                begin
                    st_reg <= ST_NO_FIT;
                end
                q_reg <= sp_top;
            end
            S_WQ:
            begin
                off_reg <= OFF_W'(cur_reg.start + cur_reg.size - SIZE_W'(req_reg)
                                  + SIZE_W'(HEADER_BYTES));
            end
            S_FPRE:
            begin
                cur_reg.used <= 1'b0;
            end
            S_FPCHK:
            begin
                if (!rdata.used)
                begin
                    p_reg   <= {1'b0, pre_reg};
                    cur_reg <= wdata;
                end
            end
            S_FNCHK:
            begin
                if (!rdata.used)
                begin
                    cur_reg <= wdata;
                end
            end
            default:
            begin
            end
        endcase
    end

    // The result goes out only between items.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !in_ch.ready)
        else $error("input taken while a result waits");

    // Steps never exceed the walk bound.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CHK) |-> (steps_reg < CNT_W'(MAX_BLOCKS)))
        else $error("walk bound exceeded");

    // Allocation results never report a free-only status.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && act_reg == ACT_ALLOC) |-> (st_reg != ST_NOT_FOUND))
        else $error("bad allocate status");

endmodule
